[rtl/core/gpu_command_port_vram_loader_top_macros.svh]
// ----------------------------------------------------------------------------
// gpu command port vram loader - assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef GPU_COMMAND_PORT_VRAM_LOADER_TOP_MACROS_SVH
`define GPU_COMMAND_PORT_VRAM_LOADER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GCPVL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcpvl check failed");
// next-cycle implication
`define GCPVL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcpvl check failed");
`else
`define GCPVL_ASSERT_NOW(label, ante, cons)
`define GCPVL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/gcpvl_pkg.sv]
// ----------------------------------------------------------------------------
// gcpvl_pkg
// shared constants and result type of the gpu command port vram loader
// ----------------------------------------------------------------------------
package gcpvl_pkg;

    localparam int VRAM_COLUMNS = 1024;
    localparam int VRAM_ROWS    = 512;
    localparam int X_W          = $clog2(VRAM_COLUMNS);
    localparam int Y_W          = $clog2(VRAM_ROWS);
    localparam int WORD_W       = 32;
    localparam int PIX_W        = 16;
    localparam int COUNT_W      = 20;
    localparam int RECT_W_W     = X_W + 1;
    localparam int RECT_H_W     = Y_W + 1;
    localparam int OUT_DATA_W   = 40;

    localparam logic [7:0] OP_LOAD      = 8'hA0;
    localparam logic [7:0] OP_STORE     = 8'hC0;
    localparam logic [7:0] OP_NOP_LAST  = 8'h02;
    localparam logic [7:0] OP_ENV_FIRST = 8'hE1;
    localparam logic [7:0] OP_ENV_LAST  = 8'hE6;
    localparam logic [7:0] OP_CTRL_LAST = 8'h08;

    localparam logic PORT_GP0 = 1'b0;
    localparam logic PORT_GP1 = 1'b1;

    typedef struct packed {
        logic             bad_opcode;
        logic             transfer_done;
        logic             last;
        logic [PIX_W-1:0] pixel_value;
        logic [Y_W-1:0]   pixel_y;
        logic [X_W-1:0]   pixel_x;
        logic             vram_write;
    } result_t;

endpackage

[rtl/core/gcpvl_engine.sv]
// ----------------------------------------------------------------------------
// gcpvl_engine
// command decode, parameter capture and load cursor; one result beat per step
// ----------------------------------------------------------------------------
module gcpvl_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       item_cmd,
    input  logic [gcpvl_pkg::WORD_W-1:0] item_word,
    output gcpvl_pkg::result_t         result,
    output logic                       item_done
);
    import gcpvl_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PARAMS,
        MODE_LOAD
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 params_seen_reg, params_seen_next;
    logic                 pending_load_reg, pending_load_next;
    logic                 phase_reg, phase_next;
    logic [X_W-1:0]       cursor_x_reg, cursor_x_next;
    logic [Y_W-1:0]       cursor_y_reg, cursor_y_next;
    logic [X_W-1:0]       row_start_reg, row_start_next;
    logic [RECT_W_W-1:0]  rect_width_reg, rect_width_next;
    logic [COUNT_W-1:0]   pixels_left_reg, pixels_left_next;

    logic [7:0]                   op;
    logic [X_W-1:0]               col_off;
    logic [X_W-1:0]               col_end;
    logic [COUNT_W-1:0]           left_dec;
    logic [RECT_W_W-1:0]          rect_w;
    logic [RECT_H_W-1:0]          rect_h;
    logic [RECT_W_W+RECT_H_W-1:0] area;
    logic [RECT_W_W+RECT_H_W-1:0] area_up;

    assign op       = item_word[WORD_W-1 -: 8];
    assign col_off  = cursor_x_reg - row_start_reg;
    assign col_end  = rect_width_reg[X_W-1:0] - 1'b1;
    assign left_dec = pixels_left_reg - 1'b1;
    // size decode: zero means the full extent
    assign rect_w   = {1'b0, item_word[X_W-1:0] - 1'b1} + 1'b1;
    assign rect_h   = {1'b0, item_word[16 +: Y_W] - 1'b1} + 1'b1;
    assign area     = rect_w * rect_h;
    assign area_up  = area + 1'b1;

    always_comb
    begin
        mode_next         = mode_reg;
        params_seen_next  = params_seen_reg;
        pending_load_next = pending_load_reg;
        phase_next        = phase_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        row_start_next    = row_start_reg;
        rect_width_next   = rect_width_reg;
        pixels_left_next  = pixels_left_reg;

        result            = '0;
        result.last       = 1'b1;
        item_done         = 1'b1;

        if (item_cmd == PORT_GP1)
        begin
            result.bad_opcode = (op > OP_CTRL_LAST);
        end
        else
        begin
            case (mode_reg)
                MODE_LOAD:
                begin
                    result.vram_write  = 1'b1;
                    result.pixel_x     = cursor_x_reg;
                    result.pixel_y     = cursor_y_reg;
                    result.pixel_value = phase_reg ? item_word[31:16] : item_word[15:0];
                    result.last        = phase_reg;
                    result.transfer_done = phase_reg && (left_dec == '0);
                    item_done          = phase_reg;
                    phase_next         = !phase_reg;
                    pixels_left_next   = left_dec;
                    // raster walk, wrapping at the vram edges
                    if (col_off == col_end)
                    begin
                        cursor_x_next = row_start_reg;
                        cursor_y_next = cursor_y_reg + 1'b1;
                    end
                    else
                    begin
                        cursor_x_next = cursor_x_reg + 1'b1;
                    end
                    if (result.transfer_done)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_PARAMS:
                begin
                    if (!params_seen_reg)
                    begin
                        cursor_x_next    = item_word[X_W-1:0];
                        cursor_y_next    = item_word[16 +: Y_W];
                        row_start_next   = item_word[X_W-1:0];
                        params_seen_next = 1'b1;
                    end
                    else
                    begin
                        rect_width_next   = rect_w;
                        // round the pixel count up to even
                        pixels_left_next  = {area_up[COUNT_W-1:1], 1'b0};
                        params_seen_next  = 1'b0;
                        mode_next         = pending_load_reg ? MODE_LOAD : MODE_IDLE;
                        pending_load_next = 1'b0;
                    end
                end
                default:
                begin
                    if (op == OP_LOAD || op == OP_STORE)
                    begin
                        mode_next         = MODE_PARAMS;
                        params_seen_next  = 1'b0;
                        pending_load_next = (op == OP_LOAD);
                    end
                    else if (op inside {[8'h00:OP_NOP_LAST], [OP_ENV_FIRST:OP_ENV_LAST]})
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        result.bad_opcode = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            params_seen_reg  <= 1'b0;
            pending_load_reg <= 1'b0;
            phase_reg        <= 1'b0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            row_start_reg    <= '0;
            rect_width_reg   <= '0;
            pixels_left_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            params_seen_reg  <= params_seen_next;
            pending_load_reg <= pending_load_next;
            phase_reg        <= phase_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            row_start_reg    <= row_start_next;
            rect_width_reg   <= rect_width_next;
            pixels_left_reg  <= pixels_left_next;
        end
    end

endmodule

[rtl/core/gpu_command_port_vram_loader_top.sv]
// ----------------------------------------------------------------------------
// gpu command port vram loader
// gp0/gp1 word port with cpu-to-vram rectangle load, one pixel write per beat
// ----------------------------------------------------------------------------
//  port group  dir  carries
//  s_*         in   tuser = cmd, tdata = data_word
//  m_*         out  tuser = vram_write, tlast = last, tdata = pixel result
//
//  a gp0 data word during a load gives two pixel beats, one after the other
//  through the single result register; every other word gives one beat.
//  the input register takes a new word in the cycle its current word retires.
//  rst_n clears all control state at once; no startup sweep.
//  a stall on m_tready holds the result register and backs up to s_tready.
// ----------------------------------------------------------------------------
`include "gpu_command_port_vram_loader_top_macros.svh"

module gpu_command_port_vram_loader_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,   // cmd
    input  logic [gcpvl_pkg::WORD_W-1:0]       s_tdata,   // data_word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_tuser,   // vram_write
    output logic                               m_tlast,   // last
    // pixel_x, pixel_y, pixel_value, transfer_done, bad_opcode, zero pad
    output logic [gcpvl_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import gcpvl_pkg::*;

    localparam int PAY_W = X_W + Y_W + PIX_W + 2;

    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [WORD_W-1:0]   in_word_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    result_t             result;
    logic                item_done;
    logic                step;
    logic                retire;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign retire   = step && item_done;
    assign s_tready = !in_valid_reg || retire;

    gcpvl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item_cmd  (in_cmd_reg),
        .item_word (in_word_reg),
        .result    (result),
        .item_done (item_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_word_reg <= s_tdata;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.vram_write;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(OUT_DATA_W - PAY_W){1'b0}}, out_reg.bad_opcode,
                       out_reg.transfer_done, out_reg.pixel_value,
                       out_reg.pixel_y, out_reg.pixel_x};

    // a non-pixel beat is always the only beat of its word
    `GCPVL_ASSERT_NOW(a_nonpixel_last, m_tvalid && !m_tuser, m_tlast)
    // a finished load is reported on the second pixel beat only
    `GCPVL_ASSERT_NOW(a_done_on_pixel, m_tvalid && out_reg.transfer_done,
                      m_tuser && m_tlast && !out_reg.bad_opcode)
    // first pixel beat of a word keeps the word held for its second beat
    `GCPVL_ASSERT_NEXT(a_word_held, step && !item_done, in_valid_reg && item_done)

endmodule

[bench/gpu_command_port_vram_loader_top_tb.sv]
// ----------------------------------------------------------------------------
// gpu command port vram loader - testbench
// drives gp0/gp1 words from a directed table and then random command
// streams, mostly complete rectangle loads. A local model of the port
// predicts every pixel and status beat, and each output beat is compared
// with it under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module gpu_command_port_vram_loader_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gcpvl_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          N_DIRECTED   = 24;
    localparam int          REPORT_MAX   = 10;
    localparam logic [7:0]  OP_POLY      = 8'h20;
    localparam logic [7:0]  OP_RECT      = 8'h60;

    typedef enum logic [1:0] {PORT_IDLE, PORT_PARAMS, PORT_LOAD} port_mode_e;

    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
        logic        typed;     // expected beat given below, not predicted
        logic        exp_bad;
    } port_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic                   s_tuser = 1'b0;
    logic [WORD_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   m_tuser;
    logic                   m_tlast;
    logic [OUT_DATA_W-1:0]  m_tdata;

    logic                   row_typed = 1'b0;
    logic                   row_bad = 1'b0;

    int                     sender_idle_pct = 0;
    int                     stall_pct = 0;
    int                     fail_count = 0;
    int                     cycle_count = 0;

    result_t                due_beats[$];
    port_write_t            stim_q[$];

    // model state
    port_mode_e             mode = PORT_IDLE;
    logic                   params_seen = 1'b0;
    logic                   pending_load = 1'b0;
    logic [X_W-1:0]         cur_x = '0;
    logic [Y_W-1:0]         cur_y = '0;
    logic [X_W-1:0]         row_x = '0;
    logic [RECT_W_W-1:0]    rect_w = '0;
    logic [COUNT_W-1:0]     px_left = '0;

    port_write_t directed_rows [0:N_DIRECTED-1] = '{
        '{PORT_GP1, 32'h0000_0000,                 1'b1, 1'b0},
        '{PORT_GP1, {OP_CTRL_LAST, 24'hFF_FFFF},   1'b1, 1'b0},
        '{PORT_GP1, {OP_CTRL_LAST + 8'd1, 24'h0},  1'b1, 1'b1},
        '{PORT_GP1, 32'hFFFF_FFFF,                 1'b1, 1'b1},
        '{PORT_GP0, 32'h0000_0000,                 1'b1, 1'b0},
        '{PORT_GP0, {OP_NOP_LAST, 24'hFF_FFFF},    1'b1, 1'b0},
        '{PORT_GP0, {OP_NOP_LAST + 8'd1, 24'h0},   1'b1, 1'b1},
        '{PORT_GP0, {OP_ENV_FIRST - 8'd1, 24'h0},  1'b1, 1'b1},
        '{PORT_GP0, {OP_ENV_FIRST, 24'h0},         1'b1, 1'b0},
        '{PORT_GP0, {OP_ENV_LAST, 24'h12_3456},    1'b1, 1'b0},
        '{PORT_GP0, {OP_ENV_LAST + 8'd1, 24'h0},   1'b1, 1'b1},
        '{PORT_GP0, {OP_POLY, 24'h0},              1'b1, 1'b1},
        '{PORT_GP0, {OP_RECT, 24'h0},              1'b1, 1'b1},
        // store consumes both parameters, top byte of a parameter is not an opcode
        '{PORT_GP0, {OP_STORE, 24'h0},             1'b1, 1'b0},
        '{PORT_GP0, 32'hFFFF_FFFF,                 1'b1, 1'b0},
        '{PORT_GP0, 32'hFFFF_0000,                 1'b1, 1'b0},
        // 3x2 load starting in the far corner, gp1 words mixed in
        '{PORT_GP0, {OP_LOAD, 24'h0},              1'b1, 1'b0},
        '{PORT_GP0, 32'h01FF_03FF,                 1'b1, 1'b0},
        '{PORT_GP1, {OP_CTRL_LAST - 8'd3, 24'h0},  1'b1, 1'b0},
        '{PORT_GP0, 32'h0002_0003,                 1'b1, 1'b0},
        '{PORT_GP1, {OP_CTRL_LAST + 8'd8, 24'h0},  1'b1, 1'b1},
        '{PORT_GP0, 32'h1234_5678,                 1'b0, 1'b0},
        '{PORT_GP0, 32'hFFFF_FFFF,                 1'b0, 1'b0},
        '{PORT_GP0, 32'h0000_0000,                 1'b0, 1'b0}
    };

    gpu_command_port_vram_loader_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // works out the beats one accepted port write produces
    function automatic void predict_port_write(input logic port, input logic [31:0] w);
        logic [7:0]     op;
        result_t        r;
        logic [X_W-1:0] off;
        logic [X_W-1:0] wm;
        logic [Y_W-1:0] hm;
        int unsigned    wd;
        int unsigned    ht;
        op = w[31:24];
        r = '0;
        r.last = 1'b1;
        if (port == PORT_GP1)
        begin
            r.bad_opcode = (op > OP_CTRL_LAST);
            due_beats = {due_beats, r};
            return;
        end
        if (mode == PORT_LOAD)
        begin
            for (int i = 0; i < 2; i++)
            begin
                r = '0;
                r.vram_write = 1'b1;
                r.pixel_x = cur_x;
                r.pixel_y = cur_y;
                r.pixel_value = (i == 0) ? w[15:0] : w[31:16];
                r.last = (i == 1);
                // raster step, both axes wrap at the vram edge
                off = cur_x - row_x;
                if (off == X_W'(rect_w - 1'b1))
                begin
                    cur_x = row_x;
                    cur_y = cur_y + 1'b1;
                end
                else
                begin
                    cur_x = cur_x + 1'b1;
                end
                px_left = px_left - 1'b1;
                if (i == 1 && px_left == '0)
                begin
                    r.transfer_done = 1'b1;
                    mode = PORT_IDLE;
                end
                due_beats = {due_beats, r};
            end
            return;
        end
        if (mode == PORT_PARAMS)
        begin
            if (!params_seen)
            begin
                cur_x = w[X_W-1:0];
                cur_y = w[16+Y_W-1:16];
                row_x = w[X_W-1:0];
                params_seen = 1'b1;
            end
            else
            begin
                wm = w[X_W-1:0] - 1'b1;
                hm = w[16+Y_W-1:16] - 1'b1;
                wd = int'(wm) + 1;
                ht = int'(hm) + 1;
                rect_w = RECT_W_W'(wd);
                // odd pixel counts round up to a whole word
                px_left = COUNT_W'((wd * ht + 1) & ~32'd1);
                params_seen = 1'b0;
                mode = pending_load ? PORT_LOAD : PORT_IDLE;
                pending_load = 1'b0;
            end
            due_beats = {due_beats, r};
            return;
        end
        if (op == OP_LOAD || op == OP_STORE)
        begin
            mode = PORT_PARAMS;
            params_seen = 1'b0;
            pending_load = (op == OP_LOAD);
        end
        else if (!(op <= OP_NOP_LAST || (op >= OP_ENV_FIRST && op <= OP_ENV_LAST)))
        begin
            r.bad_opcode = 1'b1;
        end
        due_beats = {due_beats, r};
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_port_write(s_tuser, s_tdata);
                if (row_typed)
                begin
                    want = '0;
                    want.last = 1'b1;
                    want.bad_opcode = row_bad;
                    void'(due_beats.pop_back());
                    due_beats = {due_beats, want};
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = '0;
                got.vram_write    = m_tuser;
                got.last          = m_tlast;
                got.pixel_x       = m_tdata[X_W-1:0];
                got.pixel_y       = m_tdata[X_W+Y_W-1:X_W];
                got.pixel_value   = m_tdata[X_W+Y_W+PIX_W-1:X_W+Y_W];
                got.transfer_done = m_tdata[X_W+Y_W+PIX_W];
                got.bad_opcode    = m_tdata[X_W+Y_W+PIX_W+1];
                if (due_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected beat: wr=%0d x=%0d y=%0d v=%h last=%0d done=%0d bad=%0d",
                                 got.vram_write, got.pixel_x, got.pixel_y, got.pixel_value,
                                 got.last, got.transfer_done, got.bad_opcode);
                end
                else
                begin
                    want = due_beats.pop_front();
                    if (got !== want || m_tdata[OUT_DATA_W-1:X_W+Y_W+PIX_W+2] !== '0)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("beat mismatch exp: wr=%0d x=%0d y=%0d v=%h last=%0d done=%0d bad=%0d",
                                     want.vram_write, want.pixel_x, want.pixel_y, want.pixel_value,
                                     want.last, want.transfer_done, want.bad_opcode);
                            $display("             got: wr=%0d x=%0d y=%0d v=%h last=%0d done=%0d bad=%0d pad=%0h",
                                     got.vram_write, got.pixel_x, got.pixel_y, got.pixel_value,
                                     got.last, got.transfer_done, got.bad_opcode,
                                     m_tdata[OUT_DATA_W-1:X_W+Y_W+PIX_W+2]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, due_beats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic port_write_t random_gp1();
        port_write_t p;
        p = '0;
        p.cmd = PORT_GP1;
        p.word = $urandom;
        if ($urandom_range(0, 1) == 0)
            p.word[31:24] = 8'($urandom_range(0, OP_CTRL_LAST));
        return p;
    endfunction

    function automatic port_write_t gp0_word(input logic [31:0] w);
        port_write_t p;
        p = '0;
        p.cmd = PORT_GP0;
        p.word = w;
        return p;
    endfunction

    // size parameter with random bits above both fields
    function automatic logic [31:0] dims_word(input int unsigned w, input int unsigned h);
        return {7'($urandom_range(0, 127)), 9'(h), 6'($urandom_range(0, 63)), 10'(w)};
    endfunction

    task automatic queue_traffic(input int n_words);
        int          start;
        int          sel;
        int unsigned w;
        int unsigned h;
        int unsigned n_data;
        logic [31:0] pos;
        start = stim_q.size();
        while (stim_q.size() - start < n_words)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 4);
                end
                else
                begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 3);
                end
                pos = $urandom;
                // bias some starts to the corner so the cursor wraps
                if ($urandom_range(0, 3) == 0)
                    pos = {7'($urandom), 9'($urandom_range(508, 511)),
                           6'($urandom), 10'($urandom_range(1019, 1023))};
                stim_q = {stim_q, gp0_word({OP_LOAD, 24'($urandom)})};
                if ($urandom_range(0, 9) == 0)
                    stim_q = {stim_q, random_gp1()};
                stim_q = {stim_q, gp0_word(pos)};
                if ($urandom_range(0, 9) == 0)
                    stim_q = {stim_q, random_gp1()};
                stim_q = {stim_q, gp0_word(dims_word(w, h))};
                n_data = (w * h + 1) / 2;
                for (int unsigned i = 0; i < n_data; i++)
                begin
                    stim_q = {stim_q, gp0_word($urandom)};
                    if ($urandom_range(0, 11) == 0)
                        stim_q = {stim_q, random_gp1()};
                end
            end
            else if (sel < 65)
            begin
                stim_q = {stim_q, gp0_word({OP_STORE, 24'($urandom)})};
                stim_q = {stim_q, gp0_word($urandom)};
                stim_q = {stim_q, gp0_word(dims_word($urandom_range(1, 1024),
                                                     $urandom_range(1, 512)))};
            end
            else if (sel < 80)
            begin
                stim_q = {stim_q, random_gp1()};
            end
            else
            begin
                pos = $urandom;
                case ($urandom_range(0, 2))
                    0: pos[31:24] = 8'($urandom_range(0, OP_NOP_LAST));
                    1: pos[31:24] = 8'($urandom_range(OP_ENV_FIRST, OP_ENV_LAST));
                    default: ;
                endcase
                // a random top byte may open a load or store; close it out
                if (pos[31:24] == OP_LOAD)
                    pos[31:24] = OP_RECT;
                if (pos[31:24] == OP_STORE)
                    pos[31:24] = OP_POLY;
                stim_q = {stim_q, gp0_word(pos)};
            end
        end
    endtask

    task automatic send_word(input port_write_t p);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= p.cmd;
        s_tdata   <= p.word;
        row_typed <= p.typed;
        row_bad   <= p.exp_bad;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_beats();
        s_tvalid <= 1'b0;
        // look at the queue away from the sampling edge
        @(negedge clk);
        while (due_beats.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int idle_plan [4];
        int stall_plan [4];
        idle_plan  = '{0, 85, 0, 8};
        stall_plan = '{0, 0, 85, 8};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed_rows[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = idle_plan[ph];
            stall_pct = stall_plan[ph];
            queue_traffic(100);
            while (stim_q.size() != 0)
                send_word(stim_q.pop_front());
            // sender holds off until every beat so far has come back
            drain_beats();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && due_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
